/* src/pwli_pkg.sv */
package pwli_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INTERP  = 3'd0;
    localparam logic [2:0] ST_LOW     = 3'd1;
    localparam logic [2:0] ST_HIGH    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_STORED  = 3'd4;
    localparam logic [2:0] ST_DROPPED = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        time_value;
        logic signed [31:0] pressure_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pressure_out;
        logic [2:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_RD_LAST,
        S_CHK_LAST,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_DIV_STEP,
        S_DIV_OUT,
        S_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;   // capture the input item
        logic rd_req;      // issue a memory read at the selected address
        logic rd_sel_last; // 0: read at index, 1: read at count-1
        logic cap_first;   // capture read data as first entry
        logic cap_last;    // capture read data as last entry
        logic cap_lo;      // capture read data as segment low end
        logic cap_hi;      // capture read data as segment high end
        logic idx_rst;     // index := 0
        logic idx_inc;     // index += 1
        logic wr_en;       // append the item to the table
        logic cnt_clr;     // empty the table
        logic mul_start;
        logic div_start;
        logic div_step;
        logic set_res;     // result from the selector below
        logic [2:0] res_sel;
    } t_ctrl;

    localparam logic [2:0] RES_ZERO   = 3'd0;
    localparam logic [2:0] RES_FIRST  = 3'd1;
    localparam logic [2:0] RES_LAST   = 3'd2;
    localparam logic [2:0] RES_LO     = 3'd3;
    localparam logic [2:0] RES_INTERP = 3'd4;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic le_first;   // t <= first time
        logic ge_last;    // t >= last time
        logic in_seg;     // lo <= t <= hi
        logic scan_end;   // index reached count - 1
        logic span_zero;
        logic mul_done;
        logic div_done;
    } t_stat;

endpackage

/* src/piecewise_linear_table_interpolator.sv */
// Piecewise-linear table interpolator. A clear transaction returns its result
// in the cycle after acceptance; a load is written, or dropped when the table
// is full, in S_OUT before its result is raised. A query reads the first and
// last entries, then scans segments, one entry per pass through S_SCAN_RD,
// S_SCAN_CHK and S_MUL, through the single table read port, then runs a
// 32-step shift-add multiplier and a 65-step restoring divider. One transaction
// is in flight at a time; the input is ready again once the result has been taken.
module piecewise_linear_table_interpolator #(
    parameter int DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pwli_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output pwli_pkg::t_out_item o_data
);
    import pwli_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic signed [31:0] res;
    logic [2:0] status;

    pwli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_data.kind),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_status (status),
        .i_stat   (stat),
        .o_ctrl   (ctrl)
    );

    pwli_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_data),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_res   (res)
    );

    assign o_data.pressure_out = res;
    assign o_data.status       = status;

endmodule

/* src/pwli_datapath.sv */
module pwli_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwli_pkg::t_in_item i_item,
    input  pwli_pkg::t_ctrl    i_ctrl,
    output pwli_pkg::t_stat    o_stat,
    output logic signed [31:0] o_res
);
    import pwli_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [63:0] mem [DEPTH];
    logic [63:0] r_rd;

    logic [31:0] r_t;
    logic [31:0] r_p;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [31:0] r_t_first, r_t_last, r_t_lo, r_t_hi;
    logic signed [31:0] r_p_first, r_p_last, r_p_lo, r_p_hi;
    logic signed [31:0] r_res;

    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] rd_addr;

    assign cnt_m1  = r_cnt - CW'(1);
    assign rd_addr = i_ctrl.rd_sel_last ? cnt_m1[AW-1:0] : r_idx[AW-1:0];

    // Table memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[r_cnt[AW-1:0]] <= {r_t, r_p};
        end
        if (i_ctrl.rd_req) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Item, count, index and captured entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctrl.wr_en) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_ctrl.load_item) begin
            r_t    <= i_item.time_value;
            r_p    <= i_item.pressure_value;
        end
        if (i_ctrl.idx_rst) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_ctrl.cap_first) begin
            r_t_first <= r_rd[63:32];
            r_p_first <= r_rd[31:0];
        end
        if (i_ctrl.cap_last) begin
            r_t_last <= r_rd[63:32];
            r_p_last <= r_rd[31:0];
        end
        if (i_ctrl.cap_lo) begin
            r_t_lo <= r_rd[63:32];
            r_p_lo <= r_rd[31:0];
        end
        if (i_ctrl.cap_hi) begin
            r_t_hi <= r_rd[63:32];
            r_p_hi <= r_rd[31:0];
        end
    end

    // Shift-add multiplier: |p1-p0| (33 bits) times dt (32 bits).
    logic        r_neg;
    logic [32:0] r_mag;
    logic [31:0] r_dt;
    logic [31:0] r_span;
    logic [64:0] r_prod;
    logic [5:0]  r_mcnt;
    logic        r_mbusy;
    logic signed [32:0] pdiff;

    assign pdiff = {r_p_hi[31], r_p_hi} - {r_p_lo[31], r_p_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_ctrl.mul_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && r_mcnt == 6'd31) begin
            r_mbusy <= 1'b0;
        end
        if (i_ctrl.mul_start) begin
            r_neg  <= pdiff[32];
            r_mag  <= pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
            r_dt   <= r_t - r_t_lo;
            r_span <= r_t_hi - r_t_lo;
            r_prod <= '0;
            r_mcnt <= '0;
        end else if (r_mbusy) begin
            if (r_dt[r_mcnt[4:0]]) begin
                r_prod <= r_prod + (65'(r_mag) << r_mcnt[4:0]);
            end
            r_mcnt <= r_mcnt + 6'd1;
        end
    end

    // Restoring divider: one quotient bit per step, 65 steps.
    logic [64:0] r_quo;
    logic [32:0] r_rem;
    logic [6:0]  r_dcnt;
    logic [32:0] rem_sh;
    logic [33:0] rem_sub;

    assign rem_sh  = {r_rem[31:0], r_quo[64]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            r_quo  <= r_prod;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_ctrl.div_step) begin
            if (!rem_sub[33]) begin
                r_rem <= rem_sub[32:0];
                r_quo <= {r_quo[63:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[63:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 7'd1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.set_res) begin
            case (i_ctrl.res_sel)
                RES_FIRST:  r_res <= r_p_first;
                RES_LAST:   r_res <= r_p_last;
                RES_LO:     r_res <= r_p_lo;
                RES_INTERP: r_res <= r_neg ? r_p_lo - r_quo[31:0]
                                           : r_p_lo + r_quo[31:0];
                default:    r_res <= '0;
            endcase
        end
    end

    assign o_res = r_res;

    always_comb begin
        o_stat.empty     = (r_cnt == '0);
        o_stat.full      = (r_cnt >= CW'(DEPTH));
        o_stat.single    = (r_cnt == CW'(1));
        o_stat.le_first  = (r_t <= r_t_first);
        o_stat.ge_last   = (r_t >= r_t_last);
        o_stat.in_seg    = (r_t >= r_t_lo) && (r_t <= r_t_hi);
        o_stat.scan_end  = (r_idx >= cnt_m1);
        o_stat.span_zero = (r_t_hi == r_t_lo);
        o_stat.mul_done  = r_mbusy && (r_mcnt == 6'd31);
        o_stat.div_done  = (r_dcnt == 7'd64);
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("entry count beyond depth");
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_en |-> !o_stat.full) else $error("write into full table");
    a_mul_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_start |-> !r_mbusy) else $error("divide during multiply");
`endif

endmodule

/* src/pwli_ctrl.sv */
module pwli_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    input  pwli_pkg::t_stat   i_stat,
    output pwli_pkg::t_ctrl   o_ctrl
);
    import pwli_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_status, n_status;
    logic r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_CLEARED;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_valid  <= n_valid;
        end
    end

    assign o_ready  = (r_state == S_IDLE) && !r_valid;
    assign o_valid  = r_valid;
    assign o_status = r_status;

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_valid  = r_valid;
        o_ctrl   = '0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_ctrl.load_item = 1'b1;
                    o_ctrl.idx_rst   = 1'b1;
                    o_ctrl.set_res   = 1'b1;
                    o_ctrl.res_sel   = RES_ZERO;
                    if (i_kind[1]) begin
                        n_state = S_RD_FIRST;
                    end else if (i_kind == KIND_CLEAR) begin
                        o_ctrl.cnt_clr = 1'b1;
                        n_status = ST_CLEARED;
                        n_valid  = 1'b1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // Load: count and item are now settled.
                if (i_stat.full) begin
                    n_status = ST_DROPPED;
                end else begin
                    o_ctrl.wr_en = 1'b1;
                    n_status = ST_STORED;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_RD_FIRST: begin
                o_ctrl.idx_rst = 1'b1;
                o_ctrl.rd_req  = 1'b1;
                if (i_stat.empty) begin
                    n_status = ST_EMPTY;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST: begin
                o_ctrl.cap_first   = 1'b1;
                o_ctrl.cap_lo      = 1'b1;
                o_ctrl.rd_req      = 1'b1;
                o_ctrl.rd_sel_last = 1'b1;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                if (i_stat.single || i_stat.le_first) begin
                    o_ctrl.set_res = 1'b1;
                    o_ctrl.res_sel = RES_FIRST;
                    n_status = ST_LOW;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_ctrl.cap_last = 1'b1;
                    n_state = S_CHK_LAST;
                end
            end
            S_CHK_LAST: begin
                if (i_stat.ge_last) begin
                    o_ctrl.set_res = 1'b1;
                    o_ctrl.res_sel = RES_LAST;
                    n_status = ST_HIGH;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_ctrl.idx_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // Read entry at index (high end of the current segment).
                o_ctrl.rd_req = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_ctrl.cap_hi = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (i_stat.in_seg) begin
                    if (i_stat.span_zero) begin
                        o_ctrl.set_res = 1'b1;
                        o_ctrl.res_sel = RES_LO;
                        n_status = ST_INTERP;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        o_ctrl.mul_start = 1'b1;
                        n_state = S_DIV;
                    end
                end else if (i_stat.scan_end) begin
                    o_ctrl.set_res = 1'b1;
                    o_ctrl.res_sel = RES_LAST;
                    n_status = ST_HIGH;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // High end becomes the next low end.
                    o_ctrl.cap_lo  = 1'b1;
                    o_ctrl.idx_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV: begin
                // Wait for the last partial product.
                if (i_stat.mul_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Load the finished product into the divider.
                o_ctrl.div_start = 1'b1;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DIV_OUT;
                end
            end
            S_DIV_OUT: begin
                o_ctrl.set_res = 1'b1;
                o_ctrl.res_sel = RES_INTERP;
                n_status = ST_INTERP;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> !r_valid || (r_status == ST_CLEARED))
        else $error("result raised out of order");
    a_wr_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.wr_en |-> (r_state == S_OUT)) else $error("stray write");
`endif

endmodule

/* dv/tb_piecewise_linear_table_interpolator.sv */
module tb_piecewise_linear_table_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import pwli_pkg::*;

    localparam int TBL_DEPTH   = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    piecewise_linear_table_interpolator #(
        .DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // Local copy of the breakpoint table.
    logic [31:0]        bp_time [TBL_DEPTH];
    logic signed [31:0] bp_pres [TBL_DEPTH];
    int                 bp_count;

    t_out_item expected_results[$];
    int        error_count;
    int        result_count;
    int        query_count;
    int        cycle_count;
    bit        hold_off_req;
    int        rx_wait;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Computes the expected result of one transaction and updates the table.
    function automatic t_out_item interpolate_item(t_in_item item);
        t_out_item         res;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic [63:0]       mag;
        logic [63:0]       span;
        logic [63:0]       dt;
        bit                found;
        res.pressure_out = '0;
        found = 1'b0;
        if (item.kind == KIND_CLEAR) begin
            bp_count = 0;
            res.status = ST_CLEARED;
        end else if (item.kind == KIND_LOAD) begin
            if (bp_count < TBL_DEPTH) begin
                bp_time[bp_count] = item.time_value;
                bp_pres[bp_count] = item.pressure_value;
                bp_count++;
                res.status = ST_STORED;
            end else begin
                res.status = ST_DROPPED;
            end
        end else if (bp_count == 0) begin
            res.status = ST_EMPTY;
        end else if (bp_count < 2 || item.time_value <= bp_time[0]) begin
            res.status = ST_LOW;
            res.pressure_out = bp_pres[0];
        end else if (item.time_value >= bp_time[bp_count - 1]) begin
            res.status = ST_HIGH;
            res.pressure_out = bp_pres[bp_count - 1];
        end else begin
            // Linear search for the first segment that holds the time.
            for (int i = 0; i + 1 < bp_count && !found; i++) begin
                if (item.time_value >= bp_time[i] && item.time_value <= bp_time[i + 1]) begin
                    found = 1'b1;
                    res.status = ST_INTERP;
                    p0 = bp_pres[i];
                    p1 = bp_pres[i + 1];
                    span = {32'd0, bp_time[i + 1]} - {32'd0, bp_time[i]};
                    dt = {32'd0, item.time_value} - {32'd0, bp_time[i]};
                    if (span == 0) begin
                        res.pressure_out = p0[31:0];
                    end else begin
                        mag = (p1 < p0) ? 64'(p0 - p1) : 64'(p1 - p0);
                        mag = (mag * dt) / span;
                        res.pressure_out = (p1 < p0) ? 32'(p0 - $signed(mag))
                                                     : 32'(p0 + $signed(mag));
                    end
                end
            end
            if (!found) begin
                res.status = ST_HIGH;
                res.pressure_out = bp_pres[bp_count - 1];
            end
        end
        return res;
    endfunction

    // Sends one transaction after a random gap and records its expectation.
    task automatic send_item(logic [1:0] kind, logic [31:0] tv, logic [31:0] pv);
        t_in_item item;
        int       gap;
        item.kind = kind;
        item.time_value = tv;
        item.pressure_value = pv;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(interpolate_item(item));
        if (item.kind[1]) query_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Extremes, empty table, single entry, clamps and kind 3.
    task automatic test_directed();
        send_item(KIND_QUERY, 32'd5, 32'd0);
        send_item(KIND_LOAD, 32'd100, 32'h8000_0000);
        send_item(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_LOAD, 32'd200, 32'h7FFF_FFFF);
        send_item(KIND_LOAD, 32'd200, 32'd50);
        send_item(KIND_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 32'd100, 32'd0);
        send_item(KIND_QUERY, 32'd150, 32'd0);
        send_item(KIND_QUERY, 32'd199, 32'd0);
        send_item(KIND_QUERY, 32'd200, 32'd0);
        send_item(2'd3, 32'h8000_0000, 32'd0);
        send_item(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // An unsorted table: the last time is below the first.
        send_item(KIND_LOAD, 32'd1000, -32'sd7);
        send_item(KIND_LOAD, 32'd10, 32'd9);
        send_item(KIND_LOAD, 32'd5, 32'd3);
        send_item(KIND_QUERY, 32'd500, 32'd0);
        send_item(KIND_QUERY, 32'd7, 32'd0);
        send_item(KIND_QUERY, 32'd2000, 32'd0);
        send_item(KIND_CLEAR, 32'd0, 32'd0);
        send_item(KIND_QUERY, 32'd1, 32'd0);
    endtask

    // Random sorted tables of small size queried many times, plus noise.
    task automatic test_random_tables(int n_items);
        int          sent;
        int          n_pts;
        logic [31:0] t;
        sent = 0;
        while (sent < n_items) begin
            send_item(KIND_CLEAR, $urandom(), $urandom());
            n_pts = $urandom_range(0, 12);
            t = $urandom_range(0, 1000);
            for (int i = 0; i < n_pts; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(KIND_LOAD, rand_word(), rand_word());
                else
                    send_item(KIND_LOAD, t, rand_word());
                if ($urandom_range(0, 5) != 0)
                    t = t + $urandom_range(0, 32'h1000_0000 >> $urandom_range(0, 20));
            end
            sent += n_pts + 1;
            for (int q = 0; q < 8; q++) begin
                send_item($urandom_range(0, 7) == 0 ? 2'd3 : KIND_QUERY,
                          ($urandom_range(0, 3) == 0) ? rand_word()
                                                      : $urandom_range(0, t + 100),
                          $urandom());
            end
            sent += 8;
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a quiet pause.
    task automatic test_backpressure();
        send_item(KIND_LOAD, 32'd0, 32'd0);
        hold_off_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(KIND_QUERY, $urandom(), 32'd0);
        wait_drained();
    endtask

    // Receiver readiness: a random wait per result, plus the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = $urandom_range(0, 11);
        end else if (hold_off_req) begin
            i_ready <= 1'b0;
            hold_off_req = 1'b0;
            for (int c = 0; c < 300; c++) @(posedge i_clk);
        end else if (o_valid && i_ready) begin
            rx_wait = $urandom_range(0, 11);
            i_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= (rx_wait == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result pressure=%0d status=%0d", $time,
                         o_data.pressure_out, o_data.status);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_data.pressure_out !== exp_res.pressure_out) begin
                    error_count++;
                    $display("%0t: pressure mismatch expected %0d actual %0d", $time,
                             exp_res.pressure_out, o_data.pressure_out);
                end
                if (o_data.status !== exp_res.status) begin
                    error_count++;
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             exp_res.status, o_data.status);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("piecewise_linear_table_interpolator verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        bp_count = 0;
        error_count = 0;
        result_count = 0;
        query_count = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_backpressure();
        test_random_tables(500);
        wait_drained();
        repeat (2300) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: missing results expected %0d actual 0", $time,
                     expected_results.size());
        end

        $display("Checked %0d results, %0d of them queries, over empty, single, sorted",
                 result_count, query_count);
        $display("and unsorted tables with random stalls on both sides.");
        if (error_count == 0) begin
            $display("piecewise_linear_table_interpolator verification clean");
        end else begin
            $display("piecewise_linear_table_interpolator verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/pwli_pkg.sv
src/pwli_datapath.sv
src/pwli_ctrl.sv
src/piecewise_linear_table_interpolator.sv
dv/tb_piecewise_linear_table_interpolator.sv
